[design/skvt_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted key-value table: shared package
// Sizes, status and request codes, controller states, the command and status
// bundles between controller and datapath, and the word normalisation helper.
// ----------------------------------------------------------------------------
package skvt_pkg;

  // Table size and word format.
  localparam int TABLE_DEPTH = 64;
  localparam int WORD_CHARS  = 8;
  localparam int WORD_W      = 64;
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 2;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int ENTRY_W     = 2 * WORD_W;

  // Request kinds.
  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_GET    = 2'd2,
    OP_FIND   = 2'd3
  } op_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EXISTS  = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SEARCH_RD,
    S_SEARCH_CMP,
    S_SHIFT_UP,
    S_INS_WR,
    S_SHIFT_DN,
    S_FIND,
    S_RESP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;       // capture a new item, start a search
    logic    srch_rd;    // read the midpoint entry
    logic    srch_lt;    // search key is below the midpoint
    logic    srch_gt;    // search key is above the midpoint
    logic    up_init;    // start the upward shift from the top entry
    logic    up_step;    // move one entry up by one place
    logic    dn_step;    // move one entry down by one place
    logic    ins_wr;     // write the new entry at the insert position
    logic    dec;        // one entry fewer
    logic    find_step;  // read the next entry during a value scan
    logic    res_hit;    // take the read entry as the result
    logic    set_sts;    // load sts_code as the result status
    status_t sts_code;
    logic    out_load;   // move the result into the output register
  } skvt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic full;
    logic lo_lt_hi;
    logic key_eq;
    logic key_lt;
    logic up_more;
    logic dn_more;
    logic find_more;
    logic rd_vld;
    logic val_eq;
    logic out_free;
  } skvt_sts_t;

  // Keep at most WORD_CHARS leading characters, stopping at the first zero.
  function automatic logic [WORD_W-1:0] norm_word(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] r;
    logic              alive;
    logic [7:0]        c;
    r     = '0;
    alive = 1'b1;
    for (int n = 0; n < 8; n++) begin
      c = w[WORD_W-1-8*n -: 8];
      if (c == 8'd0 || n >= WORD_CHARS) begin
        alive = 1'b0;
      end
      if (alive) begin
        r[WORD_W-1-8*n -: 8] = c;
      end
    end
    return r;
  endfunction

endpackage

[design/skvt_ctrl.sv]
// ----------------------------------------------------------------------------
// Sorted key-value table: controller
// Sequences one request at a time: binary search, shifting for insert and
// remove, the linear value scan, and hand-over to the output register.
// ----------------------------------------------------------------------------
module skvt_ctrl
  import skvt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  skvt_sts_t sts,
  output skvt_cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Items are taken only when idle and out of reset.
  assign in_stall = !(rst_n && state_r == S_IDLE);

  // Next state and commands.
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.sts_code = ST_OK;
    case (state_r)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts.op == OP_FIND) begin
          state_nxt = S_FIND;
        end else if (sts.op == OP_INSERT && sts.full) begin
          cmd.set_sts  = 1'b1;
          cmd.sts_code = ST_FULL;
          state_nxt    = S_RESP;
        end else begin
          state_nxt = S_SEARCH_RD;
        end
      end
      S_SEARCH_RD: begin
        if (sts.lo_lt_hi) begin
          cmd.srch_rd = 1'b1;
          state_nxt   = S_SEARCH_CMP;
        end else if (sts.op == OP_INSERT) begin
          cmd.up_init = 1'b1;
          state_nxt   = S_SHIFT_UP;
        end else begin
          // The status was preset to not found when the item was loaded.
          state_nxt = S_RESP;
        end
      end
      S_SEARCH_CMP: begin
        if (sts.key_eq) begin
          case (sts.op)
            OP_INSERT: begin
              cmd.set_sts  = 1'b1;
              cmd.sts_code = ST_EXISTS;
              state_nxt    = S_RESP;
            end
            OP_REMOVE: begin
              state_nxt = S_SHIFT_DN;
            end
            default: begin
              cmd.res_hit = 1'b1;
              state_nxt   = S_RESP;
            end
          endcase
        end else if (sts.key_lt) begin
          cmd.srch_lt = 1'b1;
          state_nxt   = S_SEARCH_RD;
        end else begin
          cmd.srch_gt = 1'b1;
          state_nxt   = S_SEARCH_RD;
        end
      end
      S_SHIFT_UP: begin
        if (sts.up_more) begin
          cmd.up_step = 1'b1;
        end else begin
          state_nxt = S_INS_WR;
        end
      end
      S_INS_WR: begin
        cmd.ins_wr   = 1'b1;
        cmd.set_sts  = 1'b1;
        cmd.sts_code = ST_OK;
        state_nxt    = S_RESP;
      end
      S_SHIFT_DN: begin
        if (sts.dn_more) begin
          cmd.dn_step = 1'b1;
        end else begin
          cmd.dec      = 1'b1;
          cmd.set_sts  = 1'b1;
          cmd.sts_code = ST_OK;
          state_nxt    = S_RESP;
        end
      end
      S_FIND: begin
        if (sts.rd_vld && sts.val_eq) begin
          cmd.res_hit = 1'b1;
          state_nxt   = S_RESP;
        end else if (sts.find_more) begin
          cmd.find_step = 1'b1;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // The output register is only loaded when it is free.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded while the output register is still occupied");

  // An insert write never happens on a full table.
  a_ins_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins_wr |-> !sts.full)
    else $error("insert written into a full table");

  // A new item is only taken after the previous result has been handed over.
  a_resp_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> (state_r == S_IDLE))
    else $error("controller did not return to idle after handing over a result");

endmodule

[design/skvt_dp.sv]
// ----------------------------------------------------------------------------
// Sorted key-value table: datapath
// Entry memory with one write and one registered read port, search bounds,
// the shift pipeline, the entry count and the result and output registers.
// ----------------------------------------------------------------------------
module skvt_dp
  import skvt_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic [OP_W-1:0]     in_op,
  input  logic [WORD_W-1:0]   in_key,
  input  logic [WORD_W-1:0]   in_value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] out_status,
  output logic [WORD_W-1:0]   out_found_key,
  output logic [WORD_W-1:0]   out_found_value,
  input  skvt_cmd_t           cmd,
  output skvt_sts_t           sts
);

  // Entry memory: key in the upper half, value in the lower half.
  logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;

  op_t               op_r;
  logic [WORD_W-1:0] key_r;
  logic [WORD_W-1:0] val_r;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  lo_r;
  logic [CNT_W-1:0]  hi_r;
  logic [CNT_W-1:0]  ptr_r;
  logic              mv_pend_r;
  logic [ADDR_W-1:0] mv_dst_r;
  logic              rd_vld_r;
  status_t           res_status_r;
  logic [WORD_W-1:0] res_key_r;
  logic [WORD_W-1:0] res_val_r;
  logic              out_valid_r;
  status_t           out_status_r;
  logic [WORD_W-1:0] out_key_r;
  logic [WORD_W-1:0] out_val_r;

  logic [CNT_W:0]     mid_sum;
  logic [CNT_W-1:0]   mid;
  logic [CNT_W:0]     ptr_inc;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic [WORD_W-1:0]  rd_key;
  logic [WORD_W-1:0]  rd_val;

  assign rd_key  = rd_data_r[ENTRY_W-1:WORD_W];
  assign rd_val  = rd_data_r[WORD_W-1:0];
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid     = mid_sum[CNT_W:1];
  assign ptr_inc = {1'b0, ptr_r} + {{CNT_W{1'b0}}, 1'b1};

  // Read port address: midpoint, entry below ptr, entry above ptr, or ptr.
  always_comb begin
    rd_en   = cmd.srch_rd || cmd.up_step || cmd.dn_step || cmd.find_step;
    rd_addr = ptr_r[ADDR_W-1:0];
    if (cmd.srch_rd) begin
      rd_addr = mid[ADDR_W-1:0];
    end else if (cmd.up_step) begin
      rd_addr = ADDR_W'(ptr_r - CNT_W'(1));
    end else if (cmd.dn_step) begin
      rd_addr = ptr_inc[ADDR_W-1:0];
    end
  end

  // Write port: a pending move, else the new entry at the insert position.
  always_comb begin
    wr_en   = mv_pend_r || cmd.ins_wr;
    wr_addr = mv_pend_r ? mv_dst_r : lo_r[ADDR_W-1:0];
    wr_data = mv_pend_r ? rd_data_r : {key_r, val_r};
  end

  // Memory ports.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Request capture, search bounds and scan pointer.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= op_t'(in_op);
      key_r <= norm_word(in_key);
      val_r <= norm_word(in_value);
      lo_r  <= '0;
      hi_r  <= count_r;
      ptr_r <= '0;
    end else begin
      if (cmd.srch_rd) begin
        ptr_r <= mid;
      end
      if (cmd.srch_lt) begin
        hi_r <= ptr_r;
      end
      if (cmd.srch_gt) begin
        lo_r <= ptr_inc[CNT_W-1:0];
      end
      if (cmd.up_init) begin
        ptr_r <= count_r;
      end
      if (cmd.up_step) begin
        ptr_r <= ptr_r - CNT_W'(1);
      end
      if (cmd.dn_step || cmd.find_step) begin
        ptr_r <= ptr_inc[CNT_W-1:0];
      end
    end
    if (cmd.up_step || cmd.dn_step) begin
      mv_dst_r <= cmd.up_step ? ptr_r[ADDR_W-1:0] : ptr_r[ADDR_W-1:0];
    end
  end

  // Move and scan tracking, entry count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_pend_r <= 1'b0;
      rd_vld_r  <= 1'b0;
      count_r   <= '0;
    end else begin
      mv_pend_r <= cmd.up_step || cmd.dn_step;
      rd_vld_r  <= cmd.find_step;
      if (cmd.ins_wr) begin
        count_r <= count_r + CNT_W'(1);
      end else if (cmd.dec) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  // Result being built for the current item.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_status_r <= ST_MISSING;
      res_key_r    <= '0;
      res_val_r    <= '0;
    end else if (cmd.res_hit) begin
      res_status_r <= ST_OK;
      res_key_r    <= rd_key;
      res_val_r    <= rd_val;
    end else if (cmd.set_sts) begin
      res_status_r <= cmd.sts_code;
    end
  end

  // Output register: holds a result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_key_r    <= res_key_r;
      out_val_r    <= res_val_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_key   = out_key_r;
  assign out_found_value = out_val_r;

  // Status towards the controller.
  always_comb begin
    sts           = '0;
    sts.op        = op_r;
    sts.full      = (count_r == CNT_W'(TABLE_DEPTH));
    sts.lo_lt_hi  = (lo_r < hi_r);
    sts.key_eq    = (key_r == rd_key);
    sts.key_lt    = (key_r < rd_key);
    sts.up_more   = (ptr_r > lo_r);
    sts.dn_more   = (ptr_inc < {1'b0, count_r});
    sts.find_more = (ptr_r < count_r);
    sts.rd_vld    = rd_vld_r;
    sts.val_eq    = (val_r == rd_val);
    sts.out_free  = !out_valid_r || !out_stall;
  end

  // The entry count never exceeds the table depth.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // A shift move and the insert write never compete for the write port.
  a_wr_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(mv_pend_r && cmd.ins_wr))
    else $error("move and insert write in the same cycle");

  // An insert adds exactly one entry.
  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins_wr |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("insert did not add one entry");

  // The search window never inverts.
  a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.srch_lt || cmd.srch_gt) |=> (lo_r <= hi_r))
    else $error("search bounds crossed");

endmodule

[design/sorted_key_value_table_top.sv]
// ----------------------------------------------------------------------------
// Sorted key-value table: top level
// A table of up to 64 key/value words kept in ascending key order. One
// request item in (insert, remove, get by key, find by value), one result out.
//
// Input channel in_*: op, key and value; taken when in_valid is high and
// in_stall is low. Output channel out_*: status, found key and found value;
// taken when out_valid is high and out_stall is low. One item is worked on
// at a time; the next item is taken while the previous result still waits
// in the output register.
// Each binary search step for get, insert and remove passes through a
// read state and a compare state on the registered memory read. Insert
// and remove then shift the entries above the position one at a time. Find
// by value reads one entry per cycle. The entry memory gives one read per
// cycle, which sets the pace of these operations. The next item can be taken
// in the cycle after the result is loaded.
// Reset (synchronous, rst_n low) empties the table and drops any pending
// result; stored entries are not cleared and need no clearing pass.
// While out_stall is high the result holds; a following item finishes its
// work and then waits for the output register to free up.
// ----------------------------------------------------------------------------
module sorted_key_value_table_top
  import skvt_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [OP_W-1:0]     in_op,
  input  logic [WORD_W-1:0]   in_key,
  input  logic [WORD_W-1:0]   in_value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] out_status,
  output logic [WORD_W-1:0]   out_found_key,
  output logic [WORD_W-1:0]   out_found_value
);

  skvt_cmd_t cmd;
  skvt_sts_t sts;

  // Request sequencer.
  skvt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Entry storage, search and result registers.
  skvt_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_op           (in_op),
    .in_key          (in_key),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_found_key   (out_found_key),
    .out_found_value (out_found_value),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule
